FILE: rtl/core/dfpr_pkg.sv
`default_nettype none

package dfpr_pkg;

    localparam int DEFAULT_POOL_DEPTH = 4096;

    localparam int KIND_W   = 2;
    localparam int COUNT_W  = 13;
    localparam int DESC_W   = 64;
    localparam int STATUS_W = 3;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 80;

    localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TAKE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RETURN  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RESV = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/core/descriptor_free_pool_ring.sv
`default_nettype none
// Path: an accepted input beat is registered into the pending stage (a take also reads
// the ring memory there), then moves on into the output register that drives m_tvalid.
// Throughput: one beat per cycle while m_tready is high; pointers and counts update
// at accept, the ring memory has one write and one registered read port.
// Reset (aresetn low, synchronous): head, tail, free and reserved counts go to zero
// and both pipeline stages empty; ring contents are not cleared.
module descriptor_free_pool_ring #(
    parameter int POOL_DEPTH = dfpr_pkg::DEFAULT_POOL_DEPTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [12:0] count, [76:13] descriptor_in, [79:77] zero
    input  wire logic [dfpr_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  wire logic [dfpr_pkg::KIND_W-1:0]     s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [2:0] status, [66:3] descriptor_out, [79:67] free_left
    output logic [dfpr_pkg::M_TDATA_W-1:0]       m_tdata
);
    import dfpr_pkg::*;

    localparam int PTR_W = $clog2(POOL_DEPTH);
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    logic [DESC_W-1:0] ring_mem [POOL_DEPTH];
    logic [DESC_W-1:0] rd_data_reg;

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic [CNT_W-1:0]  resv_reg, resv_next;

    logic                pend_valid_reg;
    logic                pend_take_reg;
    logic [STATUS_W-1:0] pend_status_reg;
    logic [COUNT_W-1:0]  pend_free_reg;

    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                accept;
    logic                pend_adv;
    logic                rd_en;
    logic                wr_en;
    logic [STATUS_W-1:0] item_status;
    logic                item_take;

    logic [KIND_W-1:0]  in_kind;
    logic [COUNT_W-1:0] in_count;
    logic [DESC_W-1:0]  in_desc;
    logic [CMP_W-1:0]   count_ext;
    logic [CMP_W-1:0]   free_ext;
    logic [CMP_W-1:0]   free_left_ext;
    logic [CNT_W:0]     total;

    logic [STATUS_W-1:0] out_status;
    logic [DESC_W-1:0]   out_desc;

    assign in_kind  = s_tuser;
    assign in_count = s_tdata[COUNT_W-1:0];
    assign in_desc  = s_tdata[COUNT_W+DESC_W-1:COUNT_W];

    assign pend_adv = pend_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !pend_valid_reg || pend_adv;
    assign accept   = s_tvalid && s_tready;

    assign count_ext = CMP_W'(in_count);
    assign free_ext  = CMP_W'(free_reg);
    assign total     = {1'b0, free_reg} + {1'b0, resv_reg};

    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        free_next   = free_reg;
        resv_next   = resv_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        item_status = ST_OK;
        item_take   = 1'b0;
        if (accept) begin
            case (in_kind)
                KIND_RESERVE: begin
                    if (count_ext > free_ext) begin
                        item_status = ST_SHORT;
                    end else begin
                        free_next = free_reg - CNT_W'(count_ext);
                        resv_next = resv_reg + CNT_W'(count_ext);
                    end
                end
                KIND_TAKE: begin
                    if (resv_reg == '0) begin
                        item_status = ST_NO_RESV;
                    end else begin
                        rd_en     = 1'b1;
                        item_take = 1'b1;
                        resv_next = resv_reg - 1'b1;
                        head_next = (head_reg == PTR_W'(POOL_DEPTH - 1)) ? '0
                                                                         : head_reg + 1'b1;
                    end
                end
                KIND_RETURN: begin
                    if (total >= (CNT_W + 1)'(POOL_DEPTH)) begin
                        item_status = ST_FULL;
                    end else begin
                        wr_en     = 1'b1;
                        free_next = free_reg + 1'b1;
                        tail_next = (tail_reg == PTR_W'(POOL_DEPTH - 1)) ? '0
                                                                         : tail_reg + 1'b1;
                        if (in_desc == '0) begin
                            item_status = ST_ZERO;
                        end
                    end
                end
                default: begin
                    item_status = ST_OK;
                end
            endcase
        end
    end

    assign free_left_ext = CMP_W'(free_next);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[tail_reg] <= in_desc;
        end
        if (rd_en) begin
            rd_data_reg <= ring_mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= '0;
            tail_reg       <= '0;
            free_reg       <= '0;
            resv_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            free_reg <= free_next;
            resv_reg <= resv_next;
            if (accept) begin
                pend_valid_reg <= 1'b1;
            end else if (pend_adv) begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_adv) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_take_reg   <= item_take;
            pend_status_reg <= item_status;
            pend_free_reg   <= free_left_ext[COUNT_W-1:0];
        end
        if (pend_adv) begin
            m_tdata_reg <= {pend_free_reg, out_desc, out_status};
        end
    end

    always_comb begin
        if (pend_take_reg) begin
            out_desc   = rd_data_reg;
            out_status = (rd_data_reg == '0) ? ST_ZERO : ST_OK;
        end else begin
            out_desc   = '0;
            out_status = pend_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total <= (CNT_W + 1)'(POOL_DEPTH))
        else $error("free plus reserved exceeds pool depth");

    a_take_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_kind == KIND_TAKE && resv_reg != '0) |=>
            (resv_reg == $past(resv_reg) - 1'b1 && $stable(free_reg)))
        else $error("take did not consume exactly one reservation");

    a_short_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_kind == KIND_RESERVE && count_ext > free_ext) |=>
            ($stable(free_reg) && $stable(resv_reg)))
        else $error("failed reserve changed the counts");

    a_pend_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_adv |=> m_tvalid_reg)
        else $error("pending result lost on its way to the output");

endmodule

`default_nettype wire
